@@ rtl/core/nbrld_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Nine-bit run-length deframer package
// Shared widths, constants and the request and result payload types.
// ----------------------------------------------------------------------------
package nbrld_pkg;

	// Field widths
	localparam int DUR_W  = 16;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 5;

	// Character format and frame length rule
	localparam int CHAR_BITS   = 11;
	localparam int BASE_LENGTH = 3;
	localparam int MAX_RESULTS = 6;

	// Default timing parameters
	localparam int BIT_PERIOD_US_DEF = 208;
	localparam int MAX_RUN_BITS_DEF  = 63;

	// Operation codes
	localparam logic OP_RUN   = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic             operation;
		logic             level;
		logic [DUR_W-1:0] duration_us;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [POS_W-1:0]  char_index;
		logic [POS_W-1:0]  frame_length;
		logic              frame_done;
		logic              last_of_step;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/core/nine_bit_run_length_deframer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Nine-bit run-length deframer
// Turns captured line runs into decoded characters of a length-framed message.
// ----------------------------------------------------------------------------
// Each run request is worked off one bit period per cycle while the block is
// not waiting on the output side: the run's rounded duration is held in a
// remainder register from which the bit period is subtracted each time one
// copy of the level is shifted into the 11-bit character register, and a run
// is saturated at MAX_RUN_BITS bits. A timeout flush shifts zeros the same
// way. Requests are taken one at a time; a decoded character is held in a
// staging register and then in the output register, so the block only waits
// on the output side when two characters are still undelivered. Every
// character that completes gives one result, but at most six results are
// reported per request; the last result caused by a request carries
// last_of_step.
module nine_bit_run_length_deframer_top #(
	parameter int BIT_PERIOD_US = nbrld_pkg::BIT_PERIOD_US_DEF,
	parameter int MAX_RUN_BITS  = nbrld_pkg::MAX_RUN_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  nbrld_pkg::item_t    item,
	output logic                result_valid,
	input  wire                 result_ready,
	output nbrld_pkg::result_t  result
);
	import nbrld_pkg::*;

	localparam int REM_W     = $clog2((2 ** DUR_W) + (BIT_PERIOD_US / 2));
	localparam int CNT_W     = $clog2(MAX_RUN_BITS + 1);
	localparam int BITPOS_W  = $clog2(CHAR_BITS + 1);
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_FINAL
	} state_t;

	// Control state
	state_t                state_q, state_d;
	logic                  in_frame_q, in_frame_d;
	logic [CHAR_BITS-1:0]  shift_q, shift_d;
	logic [BITPOS_W-1:0]   bitpos_q, bitpos_d;
	logic [POS_W-1:0]      charpos_q, charpos_d;
	logic [POS_W-1:0]      explen_q, explen_d;
	logic [RES_CNT_W-1:0]  res_cnt_q, res_cnt_d;
	logic                  pend_v_q, pend_v_d;
	logic                  out_v_q, out_v_d;

	// Payload registers
	logic [REM_W-1:0]      rem_q, rem_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  level_q, level_d;
	result_t               pend_q, pend_d;
	result_t               out_q, out_d;

	// Combinational working signals
	logic                  out_free;
	logic                  can_emit;
	logic                  push_en;
	logic                  push_bit;
	logic [CHAR_BITS-1:0]  shifted;
	logic [BITPOS_W-1:0]   bitpos_inc;
	logic [BYTE_W-1:0]     raw_byte;
	logic [BYTE_W-1:0]     dec_byte;
	logic [POS_W-1:0]      new_len;
	logic [POS_W-1:0]      new_pos;
	logic                  done;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_v_q;
	assign result       = out_q;

	// Next-state logic for the sequencer, the character register and results.
	always_comb begin
		state_d    = state_q;
		in_frame_d = in_frame_q;
		shift_d    = shift_q;
		bitpos_d   = bitpos_q;
		charpos_d  = charpos_q;
		explen_d   = explen_q;
		res_cnt_d  = res_cnt_q;
		pend_v_d   = pend_v_q;
		out_v_d    = out_v_q;
		rem_d      = rem_q;
		cnt_d      = cnt_q;
		level_d    = level_q;
		pend_d     = pend_q;
		out_d      = out_q;

		push_en    = 1'b0;
		push_bit   = (state_q == ST_RUN) ? level_q : 1'b0;
		shifted    = {shift_q[CHAR_BITS-2:0], push_bit};
		bitpos_inc = bitpos_q + BITPOS_W'(1);
		raw_byte   = ~shifted[BYTE_W+1:2];
		for (int i = 0; i < BYTE_W; i++) begin
			dec_byte[i] = raw_byte[BYTE_W-1-i];
		end
		new_len    = (charpos_q == POS_W'(1)) ?
			POS_W'(BASE_LENGTH) + {1'b0, dec_byte[3:0]} : explen_q;
		new_pos    = charpos_q + POS_W'(1);
		done       = (new_pos == new_len);

		// The output register empties when its result is taken.
		if (out_v_q && result_ready) begin
			out_v_d = 1'b0;
		end
		out_free = !out_v_q || result_ready;
		can_emit = !pend_v_q || out_free;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					res_cnt_d = '0;
					if (item.operation == OP_RUN) begin
						rem_d   = REM_W'(item.duration_us) + REM_W'(BIT_PERIOD_US / 2);
						cnt_d   = '0;
						level_d = item.level;
						if (in_frame_q || item.level) begin
							if (!in_frame_q) begin
								in_frame_d = 1'b1;
								explen_d   = POS_W'(BASE_LENGTH);
								charpos_d  = '0;
								bitpos_d   = '0;
								shift_d    = '0;
							end
							state_d = ST_RUN;
						end
					end else if (in_frame_q) begin
						if (bitpos_q != '0) begin
							state_d = ST_FLUSH;
						end else begin
							in_frame_d = 1'b0;
						end
					end
				end
			end
			ST_RUN: begin
				if (rem_q < REM_W'(BIT_PERIOD_US) || cnt_q == CNT_W'(MAX_RUN_BITS)) begin
					state_d = ST_FINAL;
				end else if (can_emit) begin
					push_en = 1'b1;
					rem_d   = rem_q - REM_W'(BIT_PERIOD_US);
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			ST_FLUSH: begin
				if (can_emit) begin
					push_en = 1'b1;
				end
			end
			ST_FINAL: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_d              = pend_q;
					out_d.last_of_step = 1'b1;
					out_v_d            = 1'b1;
					pend_v_d           = 1'b0;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Shift one bit in and decode the character once it is complete.
		if (push_en) begin
			if (bitpos_inc == BITPOS_W'(CHAR_BITS)) begin
				explen_d  = new_len;
				charpos_d = new_pos;
				shift_d   = '0;
				bitpos_d  = '0;
				if (res_cnt_q < RES_CNT_W'(MAX_RESULTS)) begin
					if (pend_v_q) begin
						out_d              = pend_q;
						out_d.last_of_step = 1'b0;
						out_v_d            = 1'b1;
					end
					pend_d.data_byte    = dec_byte;
					pend_d.char_index   = charpos_q;
					pend_d.frame_length = new_len;
					pend_d.frame_done   = done;
					pend_d.last_of_step = 1'b0;
					pend_v_d            = 1'b1;
					res_cnt_d           = res_cnt_q + RES_CNT_W'(1);
				end
				if (done || !push_bit) begin
					state_d = ST_FINAL;
				end
				if (done || state_q == ST_FLUSH) begin
					in_frame_d = 1'b0;
				end
			end else begin
				shift_d  = shifted;
				bitpos_d = bitpos_inc;
			end
		end
	end

	// Sequencer state, frame state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_frame_q <= 1'b0;
			shift_q    <= '0;
			bitpos_q   <= '0;
			charpos_q  <= '0;
			explen_q   <= POS_W'(BASE_LENGTH);
			res_cnt_q  <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_frame_q <= in_frame_d;
			shift_q    <= shift_d;
			bitpos_q   <= bitpos_d;
			charpos_q  <= charpos_d;
			explen_q   <= explen_d;
			res_cnt_q  <= res_cnt_d;
			pend_v_q   <= pend_v_d;
			out_v_q    <= out_v_d;
		end
	end

	// Run remainder, bit count and result payloads.
	always_ff @(posedge clk) begin
		rem_q   <= rem_d;
		cnt_q   <= cnt_d;
		level_q <= level_d;
		pend_q  <= pend_d;
		out_q   <= out_d;
	end

endmodule
`default_nettype wire

@@ verif/nine_bit_run_length_deframer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nine-bit run-length deframer testbench
// Feeds line runs and timeout flushes into the deframer, predicts every
// decoded character with a behavioural copy of the framing rules, and checks
// each delivered result field by field. It starts with hand-picked requests
// that cover the corner cases. Random frames follow, mostly well formed with
// random content, mixed with noise, cut-short frames and flushes. Both sides
// of the block idle at random.
// ----------------------------------------------------------------------------
module nine_bit_run_length_deframer_top_tb;
	import nbrld_pkg::*;

	localparam int BIT_PERIOD     = BIT_PERIOD_US_DEF;
	localparam int MAX_RUN        = MAX_RUN_BITS_DEF;
	localparam int NUM_ITEMS      = 250;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 150;

	// Behavioural deframer with a queue of the characters it expects to see.
	class deframer_scoreboard;
		bit        in_frame;
		bit [10:0] char_shift;
		bit [3:0]  bit_count;
		bit [4:0]  char_count;
		bit [4:0]  frame_len;
		result_t   expected_chars[$];
		result_t   step_chars[$];
		int        errors;

		function new();
			in_frame   = 1'b0;
			char_shift = '0;
			bit_count  = '0;
			char_count = '0;
			frame_len  = 5'(BASE_LENGTH);
			errors     = 0;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		// Shift one line bit in; returns 1 once a whole character is held.
		function bit shift_line_bit(bit b);
			char_shift = {char_shift[9:0], b};
			bit_count  = bit_count + 4'd1;
			return bit_count >= CHAR_BITS;
		endfunction

		// Decode the held character; returns 1 if it completes the frame.
		function bit complete_char();
			bit [7:0] raw;
			bit [7:0] data_v;
			bit [4:0] idx;
			bit       done;
			result_t  r;
			raw = ~char_shift[9:2];
			for (int k = 0; k < 8; k++)
				data_v[k] = raw[7-k];
			idx = char_count;
			if (idx == 5'd1)
				frame_len = 5'(BASE_LENGTH + data_v[3:0]);
			char_count = char_count + 5'd1;
			done = (char_count == frame_len);
			if (step_chars.size() < MAX_RESULTS) begin
				r.data_byte    = data_v;
				r.char_index   = idx;
				r.frame_length = frame_len;
				r.frame_done   = done;
				r.last_of_step = 1'b0;
				step_chars.push_back(r);
			end
			char_shift = '0;
			bit_count  = '0;
			if (done)
				in_frame = 1'b0;
			return done;
		endfunction

		// Work out the characters an accepted request causes; returns 0 if
		// the block merely ignores it.
		function bit note_request(item_t it);
			int unsigned nbits;
			bit          live;
			live = 1'b1;
			step_chars.delete();
			if (it.operation == OP_RUN) begin
				nbits = (32'(it.duration_us) + BIT_PERIOD / 2) / BIT_PERIOD;
				if (nbits > MAX_RUN)
					nbits = MAX_RUN;
				if (!in_frame && !it.level) begin
					live = 1'b0;
				end else begin
					if (!in_frame) begin
						in_frame   = 1'b1;
						frame_len  = 5'(BASE_LENGTH);
						char_count = '0;
						bit_count  = '0;
						char_shift = '0;
					end
					for (int unsigned i = 0; i < nbits; i++) begin
						if (shift_line_bit(it.level)) begin
							if (complete_char())
								break;
							// A character never begins with a zero, so the
							// rest of a low run is dropped.
							if (!it.level)
								break;
						end
					end
				end
			end else if (in_frame) begin
				// Timeout: pad any partial character with zeros and close.
				if (bit_count != 0) begin
					while (!shift_line_bit(1'b0)) begin
					end
					void'(complete_char());
				end
				in_frame   = 1'b0;
				bit_count  = '0;
				char_shift = '0;
			end else begin
				live = 1'b0;
			end
			if (step_chars.size() != 0)
				step_chars[step_chars.size()-1].last_of_step = 1'b1;
			foreach (step_chars[i])
				expected_chars.push_back(step_chars[i]);
			return live;
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected result: data_byte %0d, char_index %0d",
					got.data_byte, got.char_index);
				errors++;
				return;
			end
			want = expected_chars.pop_front();
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("char_index", want.char_index, got.char_index);
			compare_field("frame_length", want.frame_length, got.frame_length);
			compare_field("frame_done", want.frame_done, got.frame_done);
			compare_field("last_of_step", want.last_of_step, got.last_of_step);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	deframer_scoreboard frames;
	int sent_items;
	int stalled_cycles;
	bit send_quiet;
	bit take_quiet;

	nine_bit_run_length_deframer_top #(
		.BIT_PERIOD_US(BIT_PERIOD),
		.MAX_RUN_BITS (MAX_RUN)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Present one request after a random gap and wait until it is taken.
	task automatic send_request(input logic op, input logic lvl, input int dur);
		int    gap;
		item_t it;
		if ($urandom_range(0, 15) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 17);
		it.operation   = op;
		it.level       = lvl;
		it.duration_us = (dur > 65535) ? 16'hFFFF : 16'(dur);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		void'(frames.note_request(it));
		sent_items++;
	endtask

	// Send one frame of random characters as line runs with timing jitter.
	// Now and then the frame is cut short and closed by a timeout.
	task automatic send_frame();
		bit [7:0]  data_v;
		bit [7:0]  raw;
		bit [10:0] ch;
		bit        line_bits[$];
		int        nchars;
		int        run_len;
		bit        cut_short;
		nchars = BASE_LENGTH;
		for (int c = 0; c < nchars; c++) begin
			data_v = 8'($urandom);
			if (c == 1) begin
				// Mostly short frames, now and then up to the longest.
				data_v[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 2));
				nchars = BASE_LENGTH + data_v[3:0];
			end
			for (int k = 0; k < 8; k++)
				raw[k] = data_v[7-k];
			ch = {1'b1, ~raw, 2'($urandom)};
			for (int k = 10; k >= 0; k--)
				line_bits.push_back(ch[k]);
		end
		cut_short = ($urandom_range(0, 4) == 0);
		if (cut_short) begin
			run_len = $urandom_range(1, line_bits.size() - 1);
			while (line_bits.size() > run_len)
				void'(line_bits.pop_back());
		end
		run_len = 0;
		foreach (line_bits[i]) begin
			run_len++;
			if (i == line_bits.size() - 1 || line_bits[i+1] != line_bits[i]) begin
				send_request(OP_RUN, line_bits[i], run_len * BIT_PERIOD
					+ int'($urandom_range(0, BIT_PERIOD - 2)) - (BIT_PERIOD / 2 - 1));
				run_len = 0;
			end
		end
		if (cut_short || $urandom_range(0, 3) == 0)
			send_request(OP_FLUSH, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
		else if ($urandom_range(0, 1) == 0)
			send_request(OP_RUN, 1'b0, $urandom_range(0, 20 * BIT_PERIOD));
	endtask

	// Result side: random stalls, with quiet stretches of none.
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				take_quiet = !take_quiet;
			stall = take_quiet ? 0 : $urandom_range(0, 17);
			@(negedge clk);
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			frames.check_result(result);
		end
	end

	// Watchdog: ends the run if nothing is accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			stalled_cycles = 0;
		end else begin
			stalled_cycles++;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Reset, directed requests, random frames and the final drain.
	initial begin
		frames         = new();
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		sent_items     = 0;
		stalled_cycles = 0;
		send_quiet     = 1'b0;
		take_quiet     = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Requests that an idle block ignores.
		send_request(OP_FLUSH, 1'b1, 65535);
		send_request(OP_RUN, 1'b0, 65535);
		send_request(OP_RUN, 1'b0, 0);
		// A zero-length high run opens a frame; a flush with nothing held
		// closes it silently.
		send_request(OP_RUN, 1'b1, 0);
		send_request(OP_FLUSH, 1'b0, 0);
		// Rounding edges, a low run that ends a character, then a padded flush.
		send_request(OP_RUN, 1'b1, BIT_PERIOD / 2 - 1);
		send_request(OP_RUN, 1'b1, BIT_PERIOD / 2);
		send_request(OP_RUN, 1'b0, 65535);
		send_request(OP_RUN, 1'b1, BIT_PERIOD + BIT_PERIOD / 2 - 1);
		send_request(OP_RUN, 1'b1, BIT_PERIOD + BIT_PERIOD / 2);
		send_request(OP_FLUSH, 1'b0, 65535);
		// Saturated high runs: the frame ends at three characters.
		send_request(OP_RUN, 1'b1, 65535);
		send_request(OP_RUN, 1'b1, 65535);
		// Longest frame, then one run that yields six characters at once.
		send_request(OP_RUN, 1'b1, BIT_PERIOD);
		send_request(OP_RUN, 1'b0, 65535);
		send_request(OP_RUN, 1'b1, BIT_PERIOD);
		send_request(OP_RUN, 1'b0, 4 * BIT_PERIOD);
		send_request(OP_RUN, 1'b1, 65535);
		send_request(OP_FLUSH, 1'b1, 0);

		// Random part: mostly well-formed frames, the rest noise.
		while (sent_items < NUM_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				send_frame();
			else
				send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 12 * BIT_PERIOD));
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (frames.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (frames.errors == 0 && frames.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
